FILE: design/dtn_pkg.sv
// Shared types and constants for the detection threshold and suppression block.
package dtn_pkg;

  localparam int DTN_MAX_KEPT = 32;
  localparam int CFG_IW       = 3;
  localparam int CFG_DW       = 16;
  localparam int QUOT_W       = 15;

  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  // register indexes on the configuration port
  localparam logic [CFG_IW-1:0] CFG_SCORE_THRESHOLD = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_FRAME_WIDTH     = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_FRAME_HEIGHT    = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_REGION_X        = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_REGION_Y        = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_REGION_WIDTH    = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_REGION_HEIGHT   = 3'd6;

  localparam logic [15:0] SCORE_THRESHOLD_RST = 16'd45875;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] raw_top;
    logic signed [15:0] raw_left;
    logic signed [15:0] raw_bottom;
    logic signed [15:0] raw_right;
    logic        [15:0] score;
    logic        [7:0]  class_id;
  } det_t;

  typedef struct packed {
    logic signed [15:0] out_top;
    logic signed [15:0] out_left;
    logic signed [15:0] out_bottom;
    logic signed [15:0] out_right;
    logic        [15:0] out_score;
    logic        [7:0]  out_class;
    logic               entry_valid;
    logic               overflow;
    logic               last;
  } res_t;

  typedef struct packed {
    logic signed [15:0] top;
    logic signed [15:0] left;
    logic signed [15:0] bottom;
    logic signed [15:0] right;
    logic        [15:0] score;
    logic        [7:0]  cls;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

FILE: design/detection_threshold_nms.sv
// Score threshold, region re-normalization and greedy per-class suppression (top level).
// A detection below the score threshold is dropped without leaving IDLE. A surviving
// detection maps its four coordinates in four parallel radix-2 dividers and is
// dropped if any coordinate maps above one; otherwise it walks the kept table held
// in a chain of cells: the head entry is tested (CMP, DEC) and rotated to the
// tail unless it is erased, and APPEND then adds the new entry unless it was
// dropped or the table is full. A flush hands out one kept entry per cycle while
// the result side takes them, and a single empty marker when nothing is kept.
// The input is stalled while an item is in work; configuration is always ready.
module detection_threshold_nms #(
  parameter int MAX_KEPT = dtn_pkg::DTN_MAX_KEPT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       det_valid,
  output logic                       det_stall,
  input  dtn_pkg::det_t              det,
  output logic                       res_valid,
  input  logic                       res_stall,
  output dtn_pkg::res_t              res,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [dtn_pkg::CFG_IW-1:0] cfg_index,
  input  logic [dtn_pkg::CFG_DW-1:0] cfg_data
);
  import dtn_pkg::*;

  localparam int CW = $clog2(MAX_KEPT + 1);

  typedef enum logic [2:0] {IDLE, DIV, CMP, DEC, APPEND, EMIT} state_t;

  state_t        state;
  logic [15:0]   score_threshold;
  logic [13:0]   frame_width, frame_height, region_width, region_height;
  logic [12:0]   region_x, region_y;

  logic [CW-1:0] count, walk_left, walk_pos, remain;
  logic          ovf, decided, drop_new, div_start;
  entry_t        new_e;

  entry_t        kept [MAX_KEPT];
  cell_ctl_t     ctl  [MAX_KEPT];
  entry_t        load_data;

  logic [3:0]         div_busy;
  logic signed [15:0] q_top, q_left, q_bottom, q_right;
  logic               hit, match, erase, drop, out_free, oob;
  logic               shift_all, load_en;
  logic [CW-1:0]      load_pos;

  assign cfg_ready = 1'b1;
  assign det_stall = (state != IDLE);
  assign out_free  = !res_valid || !res_stall;

  dtn_div u_div_top (.clk, .rst, .start(div_start), .raw(det.raw_top), .fdim(frame_height),
    .off(region_y), .rdim(region_height), .busy(div_busy[0]), .q(q_top));
  dtn_div u_div_left (.clk, .rst, .start(div_start), .raw(det.raw_left), .fdim(frame_width),
    .off(region_x), .rdim(region_width), .busy(div_busy[1]), .q(q_left));
  dtn_div u_div_bottom (.clk, .rst, .start(div_start), .raw(det.raw_bottom),
    .fdim(frame_height), .off(region_y), .rdim(region_height), .busy(div_busy[2]),
    .q(q_bottom));
  dtn_div u_div_right (.clk, .rst, .start(div_start), .raw(det.raw_right), .fdim(frame_width),
    .off(region_x), .rdim(region_width), .busy(div_busy[3]), .q(q_right));

  dtn_iou u_iou (.clk, .a(new_e), .b(kept[0]), .hit);

  always_comb begin
    div_start = (state == IDLE) && det_valid && !det.kind && (det.score >= score_threshold);
    oob   = (q_top > ONE_Q14) || (q_left > ONE_Q14) || (q_bottom > ONE_Q14) ||
            (q_right > ONE_Q14);
    match = (state == DEC) && !decided && hit;
    erase = match && (new_e.score > kept[0].score);
    drop  = match && !erase;
    shift_all = 1'b0;
    load_en   = 1'b0;
    load_pos  = walk_pos;
    load_data = new_e;
    unique case (state)
      DEC: begin
        // rotate head to the tail unless it is erased
        shift_all = 1'b1;
        load_en   = !erase;
        load_pos  = walk_pos - CW'(1);
        load_data = kept[0];
      end
      APPEND: load_en = !drop_new && (walk_pos != CW'(MAX_KEPT));
      EMIT:   shift_all = out_free && (remain != '0);
      default: ;
    endcase
  end

  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
    entry_t nbr;
    if (i == MAX_KEPT - 1) begin : g_end
      assign nbr = kept[i];
    end else begin : g_mid
      assign nbr = kept[i+1];
    end
    assign ctl[i] = '{shift: shift_all, load: load_en && (load_pos == CW'(i))};
    dtn_cell u_cell (.clk, .ctl(ctl[i]), .nbr, .load_data, .q(kept[i]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= IDLE;
      score_threshold <= SCORE_THRESHOLD_RST;
      frame_width     <= 14'd1;
      frame_height    <= 14'd1;
      region_x        <= '0;
      region_y        <= '0;
      region_width    <= 14'd1;
      region_height   <= 14'd1;
      count           <= '0;
      ovf             <= 1'b0;
      res_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SCORE_THRESHOLD: score_threshold <= cfg_data;
          CFG_FRAME_WIDTH:     frame_width     <= cfg_data[13:0];
          CFG_FRAME_HEIGHT:    frame_height    <= cfg_data[13:0];
          CFG_REGION_X:        region_x        <= cfg_data[12:0];
          CFG_REGION_Y:        region_y        <= cfg_data[12:0];
          CFG_REGION_WIDTH:    region_width    <= cfg_data[13:0];
          CFG_REGION_HEIGHT:   region_height   <= cfg_data[13:0];
          default: ;
        endcase
      end
      // EMIT drives the result valid itself
      if (!res_stall && (state != EMIT)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (det_valid) begin
            new_e.score <= det.score;
            new_e.cls   <= det.class_id;
            remain      <= count;
            if (det.kind) begin
              state <= EMIT;
            end else if (div_start) begin
              state <= DIV;
            end
          end
        end
        DIV: begin
          if (div_busy == 4'd0) begin
            new_e.top    <= q_top;
            new_e.left   <= q_left;
            new_e.bottom <= q_bottom;
            new_e.right  <= q_right;
            walk_left    <= count;
            walk_pos     <= count;
            decided      <= 1'b0;
            drop_new     <= 1'b0;
            priority if (oob) begin
              state <= IDLE;
            end else if (count == '0) begin
              state <= APPEND;
            end else begin
              state <= CMP;
            end
          end
        end
        CMP: state <= DEC;
        DEC: begin
          decided   <= decided || match;
          drop_new  <= drop_new || drop;
          walk_left <= walk_left - CW'(1);
          if (erase) begin
            walk_pos <= walk_pos - CW'(1);
          end
          state <= (walk_left == CW'(1)) ? APPEND : CMP;
        end
        APPEND: begin
          if (drop_new) begin
            count <= walk_pos;
          end else if (walk_pos == CW'(MAX_KEPT)) begin
            count <= walk_pos;
            ovf   <= 1'b1;
          end else begin
            count <= walk_pos + CW'(1);
          end
          state <= IDLE;
        end
        EMIT: begin
          if (out_free) begin
            res_valid        <= 1'b1;
            res.entry_valid  <= (remain != '0);
            res.overflow     <= ovf;
            res.last         <= (remain <= CW'(1));
            if (remain == '0) begin
              res.out_top    <= '0;
              res.out_left   <= '0;
              res.out_bottom <= '0;
              res.out_right  <= '0;
              res.out_score  <= '0;
              res.out_class  <= '0;
            end else begin
              res.out_top    <= kept[0].top;
              res.out_left   <= kept[0].left;
              res.out_bottom <= kept[0].bottom;
              res.out_right  <= kept[0].right;
              res.out_score  <= kept[0].score;
              res.out_class  <= kept[0].cls;
            end
            remain <= (remain == '0) ? '0 : remain - CW'(1);
            if (remain <= CW'(1)) begin
              count <= '0;
              ovf   <= 1'b0;
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_KEPT))
    else $error("kept count beyond table size");

  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.entry_valid |-> res.last)
    else $error("empty marker not marked last");

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    div_busy[0] |-> (div_busy == 4'hF) || $past(div_busy[0]))
    else $error("coordinate dividers out of step");

  a_walk_pos: assert property (@(posedge clk) disable iff (rst)
    state == DEC |-> walk_pos <= count && walk_left != '0)
    else $error("walk position out of range");

endmodule

FILE: design/dtn_cell.sv
// One slot of the kept-box chain: takes its neighbor's entry or a loaded entry.
module dtn_cell (
  input  logic               clk,
  input  dtn_pkg::cell_ctl_t ctl,
  input  dtn_pkg::entry_t    nbr,
  input  dtn_pkg::entry_t    load_data,
  output dtn_pkg::entry_t    q
);
  import dtn_pkg::*;

  entry_t slot;

  always_ff @(posedge clk) begin
    priority if (ctl.load) begin
      slot <= load_data;
    end else if (ctl.shift) begin
      slot <= nbr;
    end
  end

  assign q = slot;

endmodule

FILE: design/dtn_div.sv
// Coordinate mapper: scale, offset and divide one coordinate, saturating to Q1.14.
module dtn_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] raw,
  input  logic        [13:0] fdim,
  input  logic        [12:0] off,
  input  logic        [13:0] rdim,
  output logic               busy,
  output logic signed [15:0] q
);
  import dtn_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_ABS, D_RUN} dphase_t;

  dphase_t            ph;
  logic signed [30:0] num;
  logic        [13:0] d;
  logic               neg;
  logic        [13:0] rem;
  logic [QUOT_W-1:0]  low;
  logic [3:0]         cnt;

  logic [29:0]        mag;
  logic [14:0]        trial;
  logic               qbit;
  logic [QUOT_W-1:0]  qq;

  always_comb begin
    mag   = 30'(num[30] ? -num : num);
    trial = {rem, low[QUOT_W-1]} - {1'b0, d};
    qbit  = ({rem, low[QUOT_W-1]} >= {1'b0, d});
    qq    = {low[QUOT_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= D_IDLE;
    end else begin
      unique case (ph)
        D_IDLE: begin
          if (start) begin
            num <= 31'(raw) * $signed({1'b0, fdim}) - $signed({3'b0, off, 14'b0});
            d   <= (rdim == 14'd0) ? 14'd1 : rdim;
            ph  <= D_ABS;
          end
        end
        D_ABS: begin
          neg <= num[30];
          rem <= mag[28:15];
          low <= mag[14:0];
          cnt <= '0;
          if (mag >= 30'({d, 15'b0})) begin
            q  <= num[30] ? -16'sd32768 : 16'sd32767;
            ph <= D_IDLE;
          end else begin
            ph <= D_RUN;
          end
        end
        D_RUN: begin
          rem <= qbit ? trial[13:0] : {rem[12:0], low[QUOT_W-1]};
          low <= qq;
          cnt <= cnt + 4'd1;
          if (cnt == 4'(QUOT_W - 1)) begin
            q  <= neg ? -$signed({1'b0, qq}) : $signed({1'b0, qq});
            ph <= D_IDLE;
          end
        end
        default: ph <= D_IDLE;
      endcase
    end
  end

  assign busy = (ph != D_IDLE);

endmodule

FILE: design/dtn_iou.sv
// Overlap test between the new box and the head entry: registered products, then compare.
module dtn_iou (
  input  logic            clk,
  input  dtn_pkg::entry_t a,
  input  dtn_pkg::entry_t b,
  output logic            hit
);
  import dtn_pkg::*;

  logic signed [15:0] mn_r, mx_l, mn_b, mx_t;
  logic signed [16:0] w, h, wa, ha, wb, hb;
  logic               pos;
  logic signed [33:0] inter, area_a, area_b;
  logic signed [35:0] uni, twice;

  always_comb begin
    mn_r = (a.right < b.right) ? a.right : b.right;
    mx_l = (a.left > b.left) ? a.left : b.left;
    mn_b = (a.bottom < b.bottom) ? a.bottom : b.bottom;
    mx_t = (a.top > b.top) ? a.top : b.top;
    w  = 17'(mn_r) - 17'(mx_l);
    h  = 17'(mn_b) - 17'(mx_t);
    wa = 17'(a.right) - 17'(a.left);
    ha = 17'(a.bottom) - 17'(a.top);
    wb = 17'(b.right) - 17'(b.left);
    hb = 17'(b.bottom) - 17'(b.top);
  end

  always_ff @(posedge clk) begin
    pos    <= (w > 17'sd0) && (h > 17'sd0) && (a.cls == b.cls);
    inter  <= w * h;
    area_a <= wa * ha;
    area_b <= wb * hb;
  end

  always_comb begin
    uni   = 36'(area_a) + 36'(area_b) - 36'(inter);
    twice = 36'(inter) <<< 1;
    hit   = pos && !uni[35] && (twice > uni);
  end

endmodule

FILE: tb/detection_threshold_nms_test.sv
// Testbench for the detection threshold and suppression block: directed and random detections.
module detection_threshold_nms_test;
  import dtn_pkg::*;

  localparam int LIMIT_CYCLES = 1500000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic det_valid = 1'b0;
  logic det_stall;
  det_t det = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  detection_threshold_nms uut (
    .clk(clk), .rst(rst),
    .det_valid(det_valid), .det_stall(det_stall), .det(det),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [15:0] thr;
  logic [13:0] fw, fh, rw, rh;
  logic [12:0] rx, ry;
  entry_t kept [$];
  logic ovf;
  res_t flush_words [$];

  int errors = 0;
  int cycles = 0;
  int hold_off = 0;
  bit stall_rand = 1'b1;

  task automatic report(input string what, input res_t got, input res_t want);
    errors++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  function automatic logic signed [15:0] map_coord(input logic signed [15:0] raw,
      input logic [13:0] fdim, input logic [12:0] off, input logic [13:0] rdim);
    longint num, d, q;
    num = longint'(raw) * longint'(fdim) - longint'(off) * 16384;
    d = (rdim == 0) ? 1 : longint'(rdim);
    q = num / d;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic bit iou_above_half(input entry_t a, input entry_t b);
    longint w, h, i, aa, ab, u, ra, rb;
    ra = (a.right < b.right) ? a.right : b.right;
    rb = (a.left > b.left) ? a.left : b.left;
    w = ra - rb;
    if (w <= 0) return 1'b0;
    ra = (a.bottom < b.bottom) ? a.bottom : b.bottom;
    rb = (a.top > b.top) ? a.top : b.top;
    h = ra - rb;
    if (h <= 0) return 1'b0;
    i = w * h;
    aa = (longint'(a.right) - a.left) * (longint'(a.bottom) - a.top);
    ab = (longint'(b.right) - b.left) * (longint'(b.bottom) - b.top);
    u = aa + ab - i;
    return (u >= 0) && (2 * i > u);
  endfunction

  task automatic predict_detection(input det_t d);
    entry_t e;
    res_t r;
    if (d.kind) begin
      if (kept.size() == 0) begin
        r = '0; r.overflow = ovf; r.last = 1'b1;
        flush_words.push_back(r);
      end else begin
        foreach (kept[k]) begin
          r.out_top = kept[k].top; r.out_left = kept[k].left;
          r.out_bottom = kept[k].bottom; r.out_right = kept[k].right;
          r.out_score = kept[k].score; r.out_class = kept[k].cls;
          r.entry_valid = 1'b1; r.overflow = ovf;
          r.last = (k == kept.size() - 1);
          flush_words.push_back(r);
        end
      end
      kept.delete();
      ovf = 1'b0;
      return;
    end
    if (d.score < thr) return;
    e.top = map_coord(d.raw_top, fh, ry, rh);
    e.left = map_coord(d.raw_left, fw, rx, rw);
    e.bottom = map_coord(d.raw_bottom, fh, ry, rh);
    e.right = map_coord(d.raw_right, fw, rx, rw);
    e.score = d.score; e.cls = d.class_id;
    if (e.top > ONE_Q14 || e.left > ONE_Q14 || e.bottom > ONE_Q14 || e.right > ONE_Q14)
      return;
    foreach (kept[k]) begin
      if (kept[k].cls != e.cls || !iou_above_half(e, kept[k])) continue;
      if (e.score <= kept[k].score) return;
      kept.delete(k);
      break;
    end
    if (kept.size() >= DTN_MAX_KEPT) ovf = 1'b1;
    else kept.push_back(e);
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_detection(input det_t d);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      // drop valid for the idle stretch
      det_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    det <= d;
    det_valid <= 1'b1;
    @(posedge clk);
    while (det_stall) @(posedge clk);
    predict_detection(d);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_index <= idx; cfg_data <= val; cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SCORE_THRESHOLD: thr = val;
      CFG_FRAME_WIDTH:     fw = val[13:0];
      CFG_FRAME_HEIGHT:    fh = val[13:0];
      CFG_REGION_X:        rx = val[12:0];
      CFG_REGION_Y:        ry = val[12:0];
      CFG_REGION_WIDTH:    rw = val[13:0];
      CFG_REGION_HEIGHT:   rh = val[13:0];
      default: ;
    endcase
  endtask

  // wait for all results, then cover the slowest detection still in work
  task automatic drain();
    det_valid <= 1'b0;
    while (flush_words.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_frame(input int w, h, x, y, regw, regh, th);
    drain();
    write_reg(CFG_FRAME_WIDTH, CFG_DW'(w));
    write_reg(CFG_FRAME_HEIGHT, CFG_DW'(h));
    write_reg(CFG_REGION_X, CFG_DW'(x));
    write_reg(CFG_REGION_Y, CFG_DW'(y));
    write_reg(CFG_REGION_WIDTH, CFG_DW'(regw));
    write_reg(CFG_REGION_HEIGHT, CFG_DW'(regh));
    write_reg(CFG_SCORE_THRESHOLD, CFG_DW'(th));
    cfg_valid <= 1'b0;
  endtask

  function automatic det_t make_box(input int t, l, b, r, sc, cl);
    det_t d;
    d.kind = 1'b0;
    d.raw_top = 16'(t); d.raw_left = 16'(l); d.raw_bottom = 16'(b); d.raw_right = 16'(r);
    d.score = 16'(sc); d.class_id = 8'(cl);
    return d;
  endfunction

  function automatic det_t flush_cmd();
    det_t d;
    d = '0;
    d.kind = 1'b1;
    d.raw_top = 16'($urandom); d.score = 16'($urandom); d.class_id = 8'($urandom);
    return d;
  endfunction

  task automatic test_directed();
    send_detection(flush_cmd());                           // empty flush
    send_detection(make_box(0, 0, 8192, 8192, 45874, 3));  // just below threshold
    send_detection(make_box(0, 0, 8192, 8192, 45875, 3));
    send_detection(make_box(0, 0, 8192, 8192, 45875, 3));  // tie drops
    send_detection(make_box(100, 100, 8292, 8292, 50000, 3)); // higher erases
    send_detection(make_box(0, 0, 8192, 8192, 60000, 4));  // other class kept
    send_detection(make_box(0, 0, 16385, 100, 65535, 5));  // above one dropped
    send_detection(make_box(-32768, -32768, 16384, 16384, 65535, 255));
    send_detection(make_box(32767, 32767, -32768, -32768, 65535, 0)); // dropped
    send_detection(make_box(8192, 8192, 0, 0, 65535, 255)); // inverted box
    send_detection(flush_cmd());
    set_frame(8192, 8192, 8191, 8191, 1, 1, 0);           // saturate low
    send_detection(make_box(16384, 0, -32768, 16384, 0, 1));
    set_frame(1, 1, 0, 0, 0, 0, 0);                       // zero region size
    send_detection(make_box(16384, 16384, -16384, 32767, 0, 2));
    send_detection(flush_cmd());
  endtask

  task automatic test_overflow();
    set_frame(1, 1, 0, 0, 1, 1, 0);
    for (int i = 0; i < 36; i++)
      send_detection(make_box(i * 400, 0, i * 400 + 100, 100, 1000, 7));
    send_detection(flush_cmd());
    send_detection(flush_cmd());
  endtask

  task automatic test_backpressure();
    set_frame(1, 1, 0, 0, 1, 1, 0);
    for (int i = 0; i < 10; i++)
      send_detection(make_box(0, i * 1000, 500, i * 1000 + 500, 2000, 9));
    hold_off = 600;
    for (int i = 0; i < 4; i++) send_detection(flush_cmd());
    for (int i = 0; i < 5; i++)
      send_detection(make_box(i * 900, 0, i * 900 + 800, 800, 3000, 1));
  endtask

  task automatic test_random(input int n);
    det_t d;
    int cx, cy, sz;
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0)
        case ($urandom_range(0, 3))
          0: set_frame(1, 1, 0, 0, 1, 1, $urandom_range(0, 40000));
          1: set_frame(640, 480, 64, 48, 512, 384, $urandom_range(0, 40000));
          2: set_frame(8192, 8192, 0, 0, 8192, 8192, $urandom_range(20000, 65535));
          default: set_frame($urandom_range(1, 8192), $urandom_range(1, 8192),
                             $urandom_range(0, 8191), $urandom_range(0, 8191),
                             $urandom_range(0, 8192), $urandom_range(1, 8192), $urandom);
        endcase
      if ($urandom_range(0, 99) < 8) d = flush_cmd();
      else if ($urandom_range(0, 99) < 15) begin
        d = '0;
        d.raw_top = 16'($urandom); d.raw_left = 16'($urandom);
        d.raw_bottom = 16'($urandom); d.raw_right = 16'($urandom);
        d.score = 16'($urandom); d.class_id = 8'($urandom);
        d.kind = 1'b0;
      end else begin
        // clustered boxes so suppression fires often
        cx = $urandom_range(0, 4) * 3000 + $urandom_range(0, 600);
        cy = $urandom_range(0, 4) * 3000 + $urandom_range(0, 600);
        sz = $urandom_range(500, 3000);
        d = make_box(cy, cx, cy + sz, cx + sz, $urandom, $urandom_range(0, 3));
      end
      send_detection(d);
    end
    send_detection(flush_cmd());
  endtask

  // result side: random stall plus a long hold-off on request
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      res_stall <= 1'b1;
    end else if (stall_rand) begin
      res_stall <= ($urandom_range(0, 99) < 25) ? 1'b1 :
                   ($urandom_range(0, 99) < 3 ? 1'b1 : 1'b0);
    end else begin
      res_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (flush_words.size() == 0) begin
        report("unexpected word", res, '0);
      end else begin
        want = flush_words.pop_front();
        if (res.out_top !== want.out_top) report("out_top", res, want);
        if (res.out_left !== want.out_left) report("out_left", res, want);
        if (res.out_bottom !== want.out_bottom) report("out_bottom", res, want);
        if (res.out_right !== want.out_right) report("out_right", res, want);
        if (res.out_score !== want.out_score) report("out_score", res, want);
        if (res.out_class !== want.out_class) report("out_class", res, want);
        if (res.entry_valid !== want.entry_valid) report("entry_valid", res, want);
        if (res.overflow !== want.overflow) report("overflow", res, want);
        if (res.last !== want.last) report("last", res, want);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("detection_threshold_nms_test NOT OK");
      $finish;
    end
  end

  initial begin
    thr = SCORE_THRESHOLD_RST; fw = 1; fh = 1; rx = 0; ry = 0; rw = 1; rh = 1;
    ovf = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_backpressure();
    stall_rand = 1'b0;
    test_random(40);
    stall_rand = 1'b1;
    test_random(310);
    drain();
    if (errors == 0 && flush_words.size() == 0)
      $display("detection_threshold_nms_test OK");
    else
      $display("detection_threshold_nms_test NOT OK");
    $finish;
  end
endmodule

FILE: sim.f
design/dtn_pkg.sv
design/dtn_cell.sv
design/dtn_div.sv
design/dtn_iou.sv
design/detection_threshold_nms.sv
tb/detection_threshold_nms_test.sv
